@@ hdl/cdq_pkg.sv @@
// Types, command and status codes shared by the deque block and its channels.
package cdq_pkg;

   localparam int DEFAULT_DEPTH = 32;
   localparam int WORD_W        = 32;
   localparam int CMD_W         = 3;
   localparam int STATUS_W      = 2;
   localparam int FILL_W        = 6;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [CMD_W-1:0]         cmd_type;
   typedef logic [STATUS_W-1:0]      status_type;
   typedef logic [FILL_W-1:0]        fill_type;

   localparam cmd_type CMD_PUSH_BACK  = 3'd0;
   localparam cmd_type CMD_PUSH_FRONT = 3'd1;
   localparam cmd_type CMD_POP_BACK   = 3'd2;
   localparam cmd_type CMD_POP_FRONT  = 3'd3;
   localparam cmd_type CMD_CLEAR      = 3'd4;

   localparam status_type STAT_DONE      = 2'd0;
   localparam status_type STAT_PUSH_FULL = 2'd1;
   localparam status_type STAT_POP_EMPTY = 2'd2;

   typedef struct packed {
      cmd_type  cmd;
      word_type push_value;
   } req_type;

   typedef struct packed {
      word_type   popped_value;
      status_type status;
      fill_type   fill_count;
      logic       is_empty;
      logic       is_full;
   } rsp_type;

endpackage

@@ hdl/cdq_req_if.sv @@
// Command channel: valid/ready handshake carrying one command word.
interface cdq_req_if;
   import cdq_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ hdl/cdq_rsp_if.sv @@
// Result channel: valid/ready handshake carrying one result word.
interface cdq_rsp_if;
   import cdq_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ hdl/circular_double_ended_queue.sv @@
// Double-ended queue over a circular single-port-read, single-port-write word store.
// The result word is registered and valid in the cycle after the command is accepted.
// Throughput: one command per cycle while the result side takes every word.
// Each command touches at most one store entry; pop data comes from the registered read port.
// Reset clears head, tail, count and the result valid; store contents stay undefined.
module circular_double_ended_queue #(
   parameter int DEPTH = cdq_pkg::DEFAULT_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   cdq_req_if.sink   req_chan,
   cdq_rsp_if.source rsp_chan
);
   import cdq_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   word_type mem [DEPTH];

   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic [IDX_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
   logic             accept;
   logic             full, empty;
   logic             wr_en, rd_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   status_type       status_in;
   logic             pop_ok_in;

   logic             rsp_valid_ff;
   word_type         rd_data_ff;
   status_type       status_ff;
   logic             pop_ok_ff;
   logic [CNT_W-1:0] rsp_count_ff;
   logic             rsp_empty_ff, rsp_full_ff;

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;

   assign full  = (count_ff == FULL_CNT);
   assign empty = (count_ff == '0);

   assign head_inc = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign head_dec = (head_ff == '0) ? LAST_IDX : head_ff - 1'b1;
   assign tail_inc = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
   assign tail_dec = (tail_ff == '0) ? LAST_IDX : tail_ff - 1'b1;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      wr_addr   = tail_ff;
      rd_addr   = head_ff;
      status_in = STAT_DONE;
      pop_ok_in = 1'b0;
      case (req_chan.data.cmd)
         CMD_PUSH_BACK: begin
            if (full) begin
               status_in = STAT_PUSH_FULL;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = tail_ff;
               tail_in  = tail_inc;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_PUSH_FRONT: begin
            if (full) begin
               status_in = STAT_PUSH_FULL;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = head_dec;
               head_in  = head_dec;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_POP_BACK: begin
            if (empty) begin
               status_in = STAT_POP_EMPTY;
            end else begin
               rd_en     = 1'b1;
               rd_addr   = tail_dec;
               tail_in   = tail_dec;
               count_in  = count_ff - 1'b1;
               pop_ok_in = 1'b1;
            end
         end
         CMD_POP_FRONT: begin
            if (empty) begin
               status_in = STAT_POP_EMPTY;
            end else begin
               rd_en     = 1'b1;
               rd_addr   = head_ff;
               head_in   = head_inc;
               count_in  = count_ff - 1'b1;
               pop_ok_in = 1'b1;
            end
         end
         CMD_CLEAR: begin
            head_in  = '0;
            tail_in  = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   // store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (accept && wr_en) begin
         mem[wr_addr] <= req_chan.data.push_value;
      end
      if (accept && rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            head_ff      <= head_in;
            tail_ff      <= tail_in;
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // hold the result word until taken
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         pop_ok_ff    <= pop_ok_in;
         rsp_count_ff <= count_in;
         rsp_empty_ff <= (count_in == '0);
         rsp_full_ff  <= (count_in == FULL_CNT);
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.data.popped_value = pop_ok_ff ? rd_data_ff : '0;
   assign rsp_chan.data.status       = status_ff;
   assign rsp_chan.data.fill_count   = FILL_W'(rsp_count_ff);
   assign rsp_chan.data.is_empty     = rsp_empty_ff;
   assign rsp_chan.data.is_full      = rsp_full_ff;

   logic [IDX_W:0] ptr_span;
   assign ptr_span = (tail_ff >= head_ff)
                   ? ({1'b0, tail_ff} - {1'b0, head_ff})
                   : ({1'b0, tail_ff} + (IDX_W+1)'(DEPTH) - {1'b0, head_ff});

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("count above depth");

   a_ptr_span: assert property (@(posedge clock) disable iff (reset)
      ((CNT_W'(ptr_span) == count_ff) || (full && (ptr_span == '0))))
      else $error("head/tail span disagrees with count");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> (count_ff == '0) && (head_ff == '0) && (tail_ff == '0) && !rsp_valid_ff)
      else $error("state not cleared by reset");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff != STAT_DONE)) |-> (rsp_chan.data.popped_value == '0))
      else $error("rejected command returned data");

   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (accept && empty && ((req_chan.data.cmd == CMD_POP_BACK) ||
                           (req_chan.data.cmd == CMD_POP_FRONT)))
      |=> (status_ff == STAT_POP_EMPTY) && (count_ff == '0))
      else $error("pop on empty not rejected");

endmodule

@@ dv/circular_double_ended_queue_tb.sv @@
// Self-checking testbench for the circular double-ended queue: directed table, then random traffic.
module circular_double_ended_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cdq_pkg::*;

   localparam int DEPTH = DEFAULT_DEPTH;

   localparam cmd_type CMD_SPARE_A = 3'd5;
   localparam cmd_type CMD_SPARE_B = 3'd6;
   localparam cmd_type CMD_SPARE_C = 3'd7;

   typedef enum int {GROW, SHRINK, CHURN} traffic_mode_type;

   typedef struct packed {
      cmd_type  cmd;
      word_type value;
      logic [5:0] reps;
      logic     typed;
      rsp_type  want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cdq_req_if req_bus ();
   cdq_rsp_if rsp_bus ();

   circular_double_ended_queue #(.DEPTH(DEPTH)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #4 clock = ~clock;

   // shadow deque
   word_type    deque_mem [DEPTH];
   int unsigned front_idx  = 0;
   int unsigned back_idx   = 0;
   int unsigned word_count = 0;

   rsp_type awaited_results [$];

   int send_idle_pct = 0;
   int stall_pct     = 0;
   bit hold_off      = 1'b0;

   int fail_count = 0;
   int n_checked  = 0;
   int n_push     = 0;
   int n_pop      = 0;
   int n_full     = 0;
   int n_empty    = 0;
   int n_clear    = 0;
   int n_spare    = 0;

   dir_row_type dir_table [24] = '{
      '{CMD_POP_FRONT,  32'sh0,        6'd1,  1'b1, '{32'sh0, STAT_POP_EMPTY, 6'd0, 1'b1, 1'b0}},
      '{CMD_POP_BACK,   32'sh0,        6'd1,  1'b1, '{32'sh0, STAT_POP_EMPTY, 6'd0, 1'b1, 1'b0}},
      '{CMD_SPARE_A,    32'sh1234,     6'd1,  1'b1, '{32'sh0, STAT_DONE, 6'd0, 1'b1, 1'b0}},
      '{CMD_SPARE_B,    32'shFFFFFFFF, 6'd1,  1'b1, '{32'sh0, STAT_DONE, 6'd0, 1'b1, 1'b0}},
      '{CMD_SPARE_C,    32'sh80000000, 6'd1,  1'b1, '{32'sh0, STAT_DONE, 6'd0, 1'b1, 1'b0}},
      '{CMD_PUSH_BACK,  32'sh7FFFFFFF, 6'd1,  1'b1, '{32'sh0, STAT_DONE, 6'd1, 1'b0, 1'b0}},
      '{CMD_PUSH_FRONT, 32'sh80000000, 6'd1,  1'b1, '{32'sh0, STAT_DONE, 6'd2, 1'b0, 1'b0}},
      '{CMD_PUSH_BACK,  32'shFFFFFFFF, 6'd1,  1'b0, '0},
      '{CMD_PUSH_FRONT, 32'sh0,        6'd1,  1'b0, '0},
      '{CMD_POP_FRONT,  32'sh0,        6'd1,  1'b1, '{32'sh0, STAT_DONE, 6'd3, 1'b0, 1'b0}},
      '{CMD_POP_FRONT,  32'sh0,        6'd1,  1'b1,
        '{32'sh80000000, STAT_DONE, 6'd2, 1'b0, 1'b0}},
      '{CMD_POP_BACK,   32'sh0,        6'd1,  1'b1,
        '{32'shFFFFFFFF, STAT_DONE, 6'd1, 1'b0, 1'b0}},
      '{CMD_POP_BACK,   32'sh0,        6'd1,  1'b1,
        '{32'sh7FFFFFFF, STAT_DONE, 6'd0, 1'b1, 1'b0}},
      '{CMD_PUSH_FRONT, 32'shA5A5A5A5, 6'd3,  1'b0, '0},
      '{CMD_POP_BACK,   32'sh0,        6'd3,  1'b0, '0},
      '{CMD_PUSH_BACK,  32'sh12345678, 6'd32, 1'b0, '0},
      '{CMD_PUSH_BACK,  32'sh0,        6'd1,  1'b1, '{32'sh0, STAT_PUSH_FULL, 6'd32, 1'b0, 1'b1}},
      '{CMD_PUSH_FRONT, 32'shFFFFFFFF, 6'd1,  1'b1, '{32'sh0, STAT_PUSH_FULL, 6'd32, 1'b0, 1'b1}},
      '{CMD_POP_FRONT,  32'sh0,        6'd2,  1'b0, '0},
      '{CMD_PUSH_FRONT, 32'sh5A5A5A5A, 6'd2,  1'b0, '0},
      '{CMD_CLEAR,      32'sh0,        6'd1,  1'b1, '{32'sh0, STAT_DONE, 6'd0, 1'b1, 1'b0}},
      '{CMD_POP_BACK,   32'sh0,        6'd1,  1'b1, '{32'sh0, STAT_POP_EMPTY, 6'd0, 1'b1, 1'b0}},
      '{CMD_PUSH_BACK,  32'sh0F0F0F0F, 6'd1,  1'b0, '0},
      '{CMD_POP_FRONT,  32'sh0,        6'd1,  1'b0, '0}
   };

   function automatic rsp_type apply_deque_cmd(cmd_type c, word_type v);
      rsp_type r;
      r = '0;
      r.status = STAT_DONE;
      case (c)
         CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
            if (word_count == DEPTH) begin
               r.status = STAT_PUSH_FULL;
               n_full++;
            end else begin
               if (c == CMD_PUSH_BACK) begin
                  deque_mem[back_idx] = v;
                  back_idx = (back_idx + 1) % DEPTH;
               end else begin
                  front_idx = (front_idx + DEPTH - 1) % DEPTH;
                  deque_mem[front_idx] = v;
               end
               word_count++;
               n_push++;
            end
         end
         CMD_POP_BACK, CMD_POP_FRONT: begin
            if (word_count == 0) begin
               r.status = STAT_POP_EMPTY;
               n_empty++;
            end else begin
               if (c == CMD_POP_BACK) begin
                  back_idx = (back_idx + DEPTH - 1) % DEPTH;
                  r.popped_value = deque_mem[back_idx];
               end else begin
                  r.popped_value = deque_mem[front_idx];
                  front_idx = (front_idx + 1) % DEPTH;
               end
               word_count--;
               n_pop++;
            end
         end
         CMD_CLEAR: begin
            front_idx = 0;
            back_idx = 0;
            word_count = 0;
            n_clear++;
         end
         default: n_spare++;
      endcase
      r.fill_count = fill_type'(word_count);
      r.is_empty = (word_count == 0);
      r.is_full = (word_count == DEPTH);
      return r;
   endfunction

   // offer one command word, hold it until taken, then log what it should return
   task automatic send_cmd(cmd_type c, word_type v, logic typed, rsp_type want);
      rsp_type pred;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data <= '{cmd: c, push_value: v};
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pred = apply_deque_cmd(c, v);
      awaited_results.push_back(typed ? want : pred);
      @(negedge clock);
   endtask

   task automatic run_random(int count);
      traffic_mode_type mode;
      int left;
      int push_pct;
      int r;
      cmd_type c;
      word_type v;
      left = 0;
      mode = CHURN;
      for (int i = 0; i < count; i++) begin
         if (left == 0) begin
            mode = traffic_mode_type'($urandom_range(2));
            left = $urandom_range(24, 80);
         end
         left--;
         push_pct = (mode == GROW) ? 80 : (mode == SHRINK) ? 20 : 50;
         r = $urandom_range(99);
         if (r == 0)
            c = CMD_CLEAR;
         else if (r == 1)
            c = cmd_type'($urandom_range(CMD_SPARE_A, CMD_SPARE_C));
         else if ($urandom_range(99) < push_pct)
            c = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
         else
            c = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
         case ($urandom_range(15))
            0: v = 32'sh7FFFFFFF;
            1: v = 32'sh80000000;
            2: v = 32'sh0;
            3: v = 32'shFFFFFFFF;
            default: v = word_type'($urandom);
         endcase
         send_cmd(c, v, 1'b0, '0);
      end
   endtask

   function automatic void compare_result(rsp_type want, rsp_type got);
      logic bad;
      bad = 1'b0;
      if (got.popped_value !== want.popped_value) begin
         $display("%0t: popped_value expected %0d got %0d", $time, want.popped_value,
                  got.popped_value);
         bad = 1'b1;
      end
      if (got.status !== want.status) begin
         $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
         bad = 1'b1;
      end
      if (got.fill_count !== want.fill_count) begin
         $display("%0t: fill_count expected %0d got %0d", $time, want.fill_count,
                  got.fill_count);
         bad = 1'b1;
      end
      if (got.is_empty !== want.is_empty) begin
         $display("%0t: is_empty expected %0b got %0b", $time, want.is_empty, got.is_empty);
         bad = 1'b1;
      end
      if (got.is_full !== want.is_full) begin
         $display("%0t: is_full expected %0b got %0b", $time, want.is_full, got.is_full);
         bad = 1'b1;
      end
      if (bad) fail_count++;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         n_checked++;
         if (awaited_results.size() == 0) begin
            $display("%0t: result word with nothing awaited: %p", $time, rsp_bus.data);
            fail_count++;
         end else begin
            compare_result(awaited_results.pop_front(), rsp_bus.data);
         end
      end
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      #3_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int drain_cycles;
      req_bus.valid = 1'b0;
      req_bus.data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_table[i]) begin
         for (int k = 0; k < dir_table[i].reps; k++) begin
            send_cmd(dir_table[i].cmd, dir_table[i].value ^ word_type'(k * 32'h9E3779B9),
                     dir_table[i].typed, dir_table[i].want);
         end
      end

      send_idle_pct = 0;
      stall_pct = 0;
      run_random(300);
      send_idle_pct = 73;
      stall_pct = 0;
      run_random(300);
      send_idle_pct = 0;
      stall_pct = 73;
      run_random(300);
      send_idle_pct = 25;
      stall_pct = 25;
      run_random(300);

      // hold off the result side so the block backs up into the command side
      send_idle_pct = 0;
      stall_pct = 0;
      fork
         begin
            hold_off = 1'b1;
            repeat (120) @(posedge clock);
            hold_off = 1'b0;
         end
         run_random(150);
      join

      req_bus.valid <= 1'b0;
      stall_pct = 0;
      drain_cycles = 0;
      while (awaited_results.size() != 0 && drain_cycles < 2000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (4) @(posedge clock);
      if (awaited_results.size() != 0) begin
         $display("%0t: %0d result words never arrived", $time, awaited_results.size());
         fail_count += awaited_results.size();
      end

      $display("Checked %0d result words: %0d pushes, %0d pops, %0d clears, %0d spare codes",
               n_checked, n_push, n_pop, n_clear, n_spare);
      $display("Rejected %0d pushes on a full deque and %0d pops on an empty one; %0d failures",
               n_full, n_empty, fail_count);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
